/* design/cff_pkg.sv */
// cff_pkg: shared constants and codes for the circular FIR filter.
// No dependencies; imported by circular_fir_filter.
package cff_pkg;

    localparam int MAX_TAPS_DEF = 128;   // default size of the coefficient store
    localparam int SAMPLE_W     = 16;    // coefficient and sample width
    localparam int ACC_W        = 32;    // accumulator / result width
    localparam int TAP_IDX_W    = 7;     // load index field width
    localparam int TAP_CNT_W    = 8;     // tap count register width
    localparam int CMD_W        = 2;

    localparam logic [TAP_CNT_W-1:0] TAPS_CFG_RST = 8'd95;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,  // write one coefficient
        CMD_RESTART = 2'd1,  // history position back to zero
        CMD_SAMPLE  = 2'd2,  // filter one sample
        CMD_NONE    = 2'd3   // no operation
    } cmd_t;

endpackage

/* design/cff_ram.sv */
// cff_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; used for the coefficient store and the sample history.
module cff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/circular_fir_filter.sv */
// circular_fir_filter: top level of the programmable-length audio FIR filter.
// Depends on cff_pkg and cff_ram.
//
// Audio FIR filter with a programmable tap count. Input words carry a command in
// s_tuser: load one coefficient, restart the history position, or filter one
// sample. Only a sample word gives a result word: the negated sum of
// coefficient times sample, each product shifted left by two, wrapping modulo
// 2^32. The oldest history sample pairs with coefficient 0 and the incoming
// sample with the last coefficient in use; the new sample then overwrites the
// oldest entry. Coefficients and history live in two single-port-read RAMs
// with registered read data, and a single 16x16 multiplier is shared over
// all taps of the effective tap count (the tap count register clamped to
// 2..MAX_TAPS). Load, restart and unused commands are done in the idle state.
// One word is worked on at a time; a new word is taken while a finished
// result is still waiting on m_tready. After reset both RAMs are cleared to
// zero by a pass over all MAX_TAPS addresses, during which s_tready stays low
// (tap count writes are still taken). The tap count may only be written while
// the block is idle.
module circular_fir_filter
    import cff_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // tap count register
    input  logic                  cfg_we,
    input  logic [TAP_CNT_W-1:0]  cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [6:0] tap_index, [22:7] value, [23] zero
    input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ACC_W-1:0]      m_tdata    // [31:0] filtered
);

    // coefficient address, history address, and a width that holds MAX_TAPS
    localparam int CA_W = $clog2(MAX_TAPS);
    localparam int HD   = MAX_TAPS - 1;
    localparam int HA_W = (HD > 1) ? $clog2(HD) : 1;
    localparam int TC_W = $clog2(MAX_TAPS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [TAP_CNT_W-1:0]   taps_cfg_reg;
    logic [CA_W-1:0]        clr_cnt_reg;
    logic [HA_W-1:0]        pos_reg;      // oldest history entry
    logic [HA_W-1:0]        idx_reg;      // history read pointer
    logic [CA_W-1:0]        k_reg;        // coefficient read pointer
    logic                   v1_reg;       // RAM read data valid
    logic                   last1_reg;    // ... and it is the final tap
    logic                   v2_reg;       // product valid
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [ACC_W-1:0]    prod_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic                   m_tvalid_reg;
    logic [ACC_W-1:0]       m_tdata_reg;

    // input fields
    cmd_t                       in_cmd;
    logic [TAP_IDX_W-1:0]       in_tap_index;
    logic signed [SAMPLE_W-1:0] in_value;

    assign in_cmd       = cmd_t'(s_tuser);
    assign in_tap_index = s_tdata[TAP_IDX_W-1:0];
    assign in_value     = s_tdata[TAP_IDX_W +: SAMPLE_W];

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // effective tap count and history length
    logic [TC_W-1:0] eff_taps;
    logic [TC_W-1:0] hist_len;
    logic [HA_W-1:0] pos_eff;

    always_comb begin
        if (taps_cfg_reg < 8'd2) begin
            eff_taps = TC_W'(2);
        end else if (32'(taps_cfg_reg) > MAX_TAPS) begin
            eff_taps = TC_W'(MAX_TAPS);
        end else begin
            eff_taps = TC_W'(taps_cfg_reg);
        end
    end

    assign hist_len = eff_taps - TC_W'(1);
    // a position left stale by a shorter tap count restarts at zero
    assign pos_eff  = (TC_W'(pos_reg) >= hist_len) ? '0 : pos_reg;

    logic idx_wrap;
    logic pos_wrap;
    logic k_last;
    assign idx_wrap = (TC_W'(idx_reg) + TC_W'(1)) >= hist_len;
    assign pos_wrap = (TC_W'(pos_reg) + TC_W'(1)) >= hist_len;
    assign k_last   = (TC_W'(k_reg) == hist_len);

    // coefficient RAM: written by the clearing pass or a load word
    logic                coef_we;
    logic [CA_W-1:0]     coef_waddr;
    logic [SAMPLE_W-1:0] coef_wdata;
    logic [SAMPLE_W-1:0] coef_rdata;
    logic                load_ok;

    assign load_ok = accept && (in_cmd == CMD_LOAD) && (32'(in_tap_index) < MAX_TAPS);

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            coef_we    = 1'b1;
            coef_waddr = clr_cnt_reg;
            coef_wdata = '0;
        end else begin
            coef_we    = load_ok;
            coef_waddr = CA_W'(in_tap_index);
            coef_wdata = in_value;
        end
    end

    // history RAM: written by the clearing pass or on commit of a sample
    logic                hist_we;
    logic [HA_W-1:0]     hist_waddr;
    logic [SAMPLE_W-1:0] hist_wdata;
    logic [SAMPLE_W-1:0] hist_rdata;
    logic                commit;

    assign commit = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            hist_we    = (32'(clr_cnt_reg) < HD);
            hist_waddr = HA_W'(clr_cnt_reg);
            hist_wdata = '0;
        end else begin
            hist_we    = commit;
            hist_waddr = pos_reg;
            hist_wdata = sample_reg;
        end
    end

    cff_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS),
        .AW    (CA_W)
    ) u_coef_ram (
        .clk   (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (k_reg),
        .rdata (coef_rdata)
    );

    cff_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HD),
        .AW    (HA_W)
    ) u_hist_ram (
        .clk   (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (idx_reg),
        .rdata (hist_rdata)
    );

    // multiplier operands: final tap takes the incoming sample
    logic signed [SAMPLE_W-1:0] mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [ACC_W-1:0]    prod_next;
    logic [ACC_W-1:0]           acc_next;

    assign mul_a     = coef_rdata;
    assign mul_b     = last1_reg ? sample_reg : hist_rdata;
    assign prod_next = mul_a * mul_b;
    assign acc_next  = acc_reg - (ACC_W'(prod_reg) << 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            taps_cfg_reg  <= TAPS_CFG_RST;
            clr_cnt_reg   <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            last1_reg     <= 1'b0;
            v2_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                taps_cfg_reg <= cfg_wdata;
            end

            // read pipeline: address -> RAM data -> product -> accumulate
            v1_reg    <= (state_reg == ST_RUN);
            last1_reg <= (state_reg == ST_RUN) && k_last;
            v2_reg    <= v1_reg;
            prod_reg  <= prod_next;
            if (v2_reg) begin
                acc_reg <= acc_next;
            end

            // a commit in the same cycle reloads the slot instead
            if (m_tvalid_reg && m_tready && !commit) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + CA_W'(1);
                    if (32'(clr_cnt_reg) == MAX_TAPS - 1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        case (in_cmd)
                            CMD_RESTART: pos_reg <= '0;
                            CMD_SAMPLE: begin
                                pos_reg    <= pos_eff;
                                idx_reg    <= pos_eff;
                                k_reg      <= '0;
                                sample_reg <= in_value;
                                acc_reg    <= '0;
                                state_reg  <= ST_RUN;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RUN: begin
                    k_reg   <= k_reg + CA_W'(1);
                    idx_reg <= idx_wrap ? '0 : idx_reg + HA_W'(1);
                    if (k_last) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!v1_reg && !v2_reg) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (commit) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= acc_reg;
                        pos_reg      <= pos_wrap ? '0 : pos_reg + HA_W'(1);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a new result only ever comes from a committing sample
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result word raised outside commit");

    // coefficient pointer never runs past the final tap while filtering
    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> TC_W'(k_reg) <= hist_len)
        else $error("coefficient pointer beyond tap count");

    // no coefficient write while a sample is in progress
    a_no_load_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN || state_reg == ST_DRAIN) |-> !coef_we)
        else $error("coefficient written during filtering");

    // the commit must not see a product still in flight
    a_pipe_empty_at_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> !v1_reg && !v2_reg)
        else $error("accumulator not settled at commit");

    // reset always starts the clearing pass
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> state_reg == ST_CLEAR)
        else $error("clearing pass not started after reset");

endmodule
